// ===== rtl/core/r2a_pkg.sv =====
// ----------------------------------------------------------------------------
// r2a_pkg: shared types and constants for the radix integer to ASCII block
// Holds the digit and character types, the control bundle that drives the
// digit cells, and the digit to character mapping.
// ----------------------------------------------------------------------------
package r2a_pkg;

    // Default sizes, handed to the top level as parameter defaults.
    localparam int VALUE_BITS_DEF = 31;
    localparam int MAX_DIGITS_DEF = 31;

    // A digit of any radix up to 36 fits in six bits, a character in seven.
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [CHAR_W-1:0]  char_t;

    // Legal radix range.
    localparam digit_t RADIX_MIN = 6'd2;
    localparam digit_t RADIX_MAX = 6'd36;

    // Character mapping constants.
    localparam digit_t DEC_LIMIT  = 6'd10;
    localparam char_t  CHAR_ZERO  = 7'h30;
    localparam char_t  CHAR_ALPHA = 7'h41;
    localparam char_t  CHAR_NONE  = 7'h00;

    // Control broadcast from the sequencer to every digit cell.
    typedef struct packed {
        logic clear;   // zero the digit ahead of a new conversion
        logic shift;   // move digits one cell toward the most significant end
    } cell_ctrl_t;

    // Map a digit value to its ASCII character: 0-9, then A-Z.
    function automatic char_t digit_to_char(input digit_t d);
        char_t ext;
        ext = {1'b0, d};
        if (d < DEC_LIMIT)
        begin
            digit_to_char = CHAR_ZERO + ext;
        end
        else
        begin
            digit_to_char = CHAR_ALPHA + ext - {1'b0, DEC_LIMIT};
        end
    endfunction

endpackage

// ===== rtl/core/r2a_cell.sv =====
// ----------------------------------------------------------------------------
// r2a_cell: one digit cell of the radix conversion row
// Holds one digit of the result. While converting, it doubles its digit, adds
// the carry from the less significant neighbor and reduces modulo the radix,
// passing the carry on through a register. While skipping and emitting, it takes the digit
// of its less significant neighbor.
// ----------------------------------------------------------------------------
module r2a_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  r2a_pkg::cell_ctrl_t ctrl,
    input  r2a_pkg::digit_t     radix,
    input  logic                en_in,
    input  logic                carry_in,
    input  r2a_pkg::digit_t     digit_in,
    output logic                en_out,
    output logic                carry_out,
    output r2a_pkg::digit_t     digit_out
);

    logic [r2a_pkg::DIGIT_W:0] dbl;
    r2a_pkg::digit_t           diff;
    logic                      overflow;
    r2a_pkg::digit_t           digit_reg;
    r2a_pkg::digit_t           digit_next;
    logic                      en_reg;
    logic                      en_next;
    logic                      carry_reg;
    logic                      carry_next;

    // Doubled digit plus incoming bit, and its reduction by the radix.
    // The doubled value stays below twice the radix, so one subtract does,
    // and the reduced digit fits in the low bits of the difference.
    assign dbl      = {digit_reg, carry_in};
    assign diff     = dbl[r2a_pkg::DIGIT_W-1:0] - radix;
    assign overflow = (dbl >= {1'b0, radix});

    // Next digit, enable and carry.
    always_comb
    begin
        digit_next = digit_reg;
        carry_next = carry_reg;
        en_next    = en_in & ~ctrl.clear;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
        else if (en_in)
        begin
            digit_next = overflow ? diff
                                  : dbl[r2a_pkg::DIGIT_W-1:0];
            carry_next = overflow;
        end
    end

    // Enable pipeline toward the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg <= 1'b0;
        end
        else
        begin
            en_reg <= en_next;
        end
    end

    // Digit and carry.
    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
        carry_reg <= carry_next;
    end

    assign en_out    = en_reg;
    assign carry_out = carry_reg;
    assign digit_out = digit_reg;

endmodule

// ===== rtl/core/radix_integer_to_ascii.sv =====
// ----------------------------------------------------------------------------
// radix_integer_to_ascii: integer to ASCII digit string in radix 2 to 36
// Converts a nonnegative integer into its digits in a chosen radix and sends
// them as ASCII characters, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   The source channel (src_valid, src_ready, value, radix) takes one value
//   per transaction. src_ready is high only while the block is idle.
//   The destination channel (dst_valid, dst_ready, digit_char, last,
//   bad_radix) sends one character per transaction; last marks the final
//   character of a value. A radix outside 2 to 36 gives a single transaction
//   with bad_radix and last set and digit_char zero.
//   Timing: the value is fed bit by bit, most significant first, into a row
//   of MAX_DIGITS digit cells; the carries travel one cell per cycle, and the
//   conversion runs until the carry wave has passed the last cell. Leading zero
//   digits are then shifted out at one per cycle, and each digit is sent once
//   the output register is free. A bad radix goes straight to the output
//   register as a single transaction.
//   Results sit in an output register, so a stalled receiver only holds the
//   digit sequencer; the next value is taken once all digits have left the
//   cells. Reset empties the output register and returns to idle.
// ----------------------------------------------------------------------------
module radix_integer_to_ascii #(
    parameter int VALUE_BITS = r2a_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = r2a_pkg::MAX_DIGITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    output logic                  src_ready,
    input  logic [VALUE_BITS-1:0] value,
    input  r2a_pkg::digit_t       radix,
    output logic                  dst_valid,
    input  logic                  dst_ready,
    output r2a_pkg::char_t        digit_char,
    output logic                  last,
    output logic                  bad_radix
);

    localparam int CNT_W = $clog2(VALUE_BITS + MAX_DIGITS);
    localparam int REM_W = $clog2(MAX_DIGITS + 1);
    localparam logic [CNT_W-1:0] FEED_END  = CNT_W'(VALUE_BITS);
    localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(VALUE_BITS + MAX_DIGITS - 2);
    localparam logic [REM_W-1:0] REM_FULL  = REM_W'(MAX_DIGITS);
    localparam logic [REM_W-1:0] REM_ONE   = REM_W'(1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_SKIP = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_BAD  = 3'd4;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [REM_W-1:0]      rem_reg;
    logic [REM_W-1:0]      rem_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    r2a_pkg::digit_t       radix_reg;
    r2a_pkg::digit_t       radix_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    r2a_pkg::char_t        char_reg;
    r2a_pkg::char_t        char_next;
    logic                  last_reg;
    logic                  last_next;
    logic                  bad_reg;
    logic                  bad_next;

    logic                  accept;
    logic                  radix_ok;
    logic                  slot_free;
    logic                  feed_en;
    r2a_pkg::digit_t       top_digit;
    r2a_pkg::cell_ctrl_t   ctrl;

    logic                  en_chain    [0:MAX_DIGITS];
    logic                  carry_chain [0:MAX_DIGITS];
    r2a_pkg::digit_t       digit_chain [0:MAX_DIGITS];

    assign src_ready = (state_reg == S_IDLE);
    assign accept    = src_valid & src_ready;
    assign radix_ok  = (radix >= r2a_pkg::RADIX_MIN) && (radix <= r2a_pkg::RADIX_MAX);
    assign slot_free = ~out_valid_reg | dst_ready;
    assign feed_en   = (state_reg == S_CONV) && (cnt_reg < FEED_END);
    assign top_digit = digit_chain[MAX_DIGITS];

    // Row of digit cells; cell 0 is the least significant digit.
    assign en_chain[0]    = feed_en;
    assign carry_chain[0] = value_reg[VALUE_BITS-1];
    assign digit_chain[0] = '0;

    for (genvar i = 0; i < MAX_DIGITS; i++)
    begin : g_cell
        r2a_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .radix     (radix_reg),
            .en_in     (en_chain[i]),
            .carry_in  (carry_chain[i]),
            .digit_in  (digit_chain[i]),
            .en_out    (en_chain[i+1]),
            .carry_out (carry_chain[i+1]),
            .digit_out (digit_chain[i+1])
        );
    end

    // Sequencer and output register loading.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        value_next     = value_reg;
        radix_next     = radix_reg;
        out_valid_next = out_valid_reg & ~dst_ready;
        char_next      = char_reg;
        last_next      = last_reg;
        bad_next       = bad_reg;
        ctrl.clear     = 1'b0;
        ctrl.shift     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    value_next = value;
                    radix_next = radix;
                    cnt_next   = '0;
                    if (radix_ok)
                    begin
                        ctrl.clear = 1'b1;
                        state_next = S_CONV;
                    end
                    else
                    begin
                        state_next = S_BAD;
                    end
                end
            end
            S_CONV:
            begin
                value_next = {value_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CONV_LAST)
                begin
                    rem_next   = REM_FULL;
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                // Drop leading zeros, but always keep one digit.
                if ((top_digit == '0) && (rem_reg != REM_ONE))
                begin
                    ctrl.shift = 1'b1;
                    rem_next   = rem_reg - 1'b1;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = r2a_pkg::digit_to_char(top_digit);
                    last_next      = (rem_reg == REM_ONE);
                    bad_next       = 1'b0;
                    ctrl.shift     = 1'b1;
                    rem_next       = rem_reg - 1'b1;
                    if (rem_reg == REM_ONE)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_BAD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = r2a_pkg::CHAR_NONE;
                    last_next      = 1'b1;
                    bad_next       = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        radix_reg <= radix_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        bad_reg   <= bad_next;
    end

    assign dst_valid  = out_valid_reg;
    assign digit_char = char_reg;
    assign last       = last_reg;
    assign bad_radix  = bad_reg;

    // An error transaction is always a lone, final, blank character.
    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && bad_radix) |-> (last && (digit_char == r2a_pkg::CHAR_NONE)))
        else $error("bad radix transaction without last or with a character");

    // A digit transaction carries a printable digit character.
    a_digit_char: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && !bad_radix) |-> (digit_char >= r2a_pkg::CHAR_ZERO))
        else $error("digit transaction below the digit range");

    // The digit count is spent exactly when the sequencer returns to idle.
    a_idle_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (rem_reg == '0))
        else $error("digits left over in idle");

    // While skipping or emitting, at least one digit remains.
    a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SKIP) || (state_reg == S_EMIT)) |-> (rem_reg != '0))
        else $error("digit count ran out before the last character");

    // The conversion counter never runs past the end of the carry wave.
    a_conv_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CONV) |-> (cnt_reg <= CONV_LAST))
        else $error("conversion counter overran");

endmodule

// ===== tb/tb_radix_integer_to_ascii.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radix_integer_to_ascii: self-checking testbench for the radix converter
// Sends values with radixes from 0 to 63 and predicts the ASCII digit string
// of each one. Every character that leaves the block is compared field by
// field with the oldest predicted character. Directed cases cover zero,
// single digits, full-width values and illegal radixes. Random traffic then
// runs under three idling mixes on the source and destination channels.
// ----------------------------------------------------------------------------
module tb_radix_integer_to_ascii;

    localparam int VALUE_W      = r2a_pkg::VALUE_BITS_DEF;
    localparam int DIGITS_MAX   = r2a_pkg::MAX_DIGITS_DEF;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE_CYCLES = 120;
    localparam int MAX_REPORTS  = 10;

    // One predicted character on the destination channel.
    typedef struct packed {
        r2a_pkg::char_t ch;
        logic           fin;
        logic           bad;
    } digit_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               src_valid = 1'b0;
    logic               src_ready;
    logic [VALUE_W-1:0] value = '0;
    r2a_pkg::digit_t    radix = '0;
    logic               dst_valid;
    logic               dst_ready = 1'b0;
    r2a_pkg::char_t     digit_char;
    logic               last;
    logic               bad_radix;

    digit_result_t pending_chars[$];
    int            src_idle_pct = 0;
    int            dst_idle_pct = 0;
    int            fail_count = 0;
    int            values_sent = 0;
    int            bad_radix_sent = 0;
    int            chars_checked = 0;
    int            cycle_count = 0;

    radix_integer_to_ascii u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_ready  (src_ready),
        .value      (value),
        .radix      (radix),
        .dst_valid  (dst_valid),
        .dst_ready  (dst_ready),
        .digit_char (digit_char),
        .last       (last),
        .bad_radix  (bad_radix)
    );

    // 50 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Run limit, in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d characters still pending",
                     cycle_count, pending_chars.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Destination stalls at the current idling rate.
    always @(posedge clk)
    begin
        dst_ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Works out the character string of one value and queues it.
    function automatic void predict_digits(input logic [VALUE_W-1:0] v,
                                           input r2a_pkg::digit_t r);
        r2a_pkg::digit_t digs [0:63];
        logic [31:0]     rest;
        int              count;
        int              keep;
        digit_result_t   item;
        rest  = {{(32 - VALUE_W){1'b0}}, v};
        count = 0;
        if (r < r2a_pkg::RADIX_MIN || r > r2a_pkg::RADIX_MAX)
        begin
            item.ch  = r2a_pkg::CHAR_NONE;
            item.fin = 1'b1;
            item.bad = 1'b1;
            pending_chars.push_back(item);
            return;
        end
        // Collect digits least significant first.
        do
        begin
            digs[count] = r2a_pkg::digit_t'(rest % r);
            rest        = rest / r;
            count++;
        end
        while (rest != 0 && count < 64);
        keep = (count > DIGITS_MAX) ? DIGITS_MAX : count;
        for (int k = 0; k < keep; k++)
        begin
            if (digs[keep - 1 - k] < r2a_pkg::DEC_LIMIT)
            begin
                item.ch = r2a_pkg::CHAR_ZERO + r2a_pkg::char_t'(digs[keep - 1 - k]);
            end
            else
            begin
                item.ch = r2a_pkg::CHAR_ALPHA
                        + r2a_pkg::char_t'(digs[keep - 1 - k] - r2a_pkg::DEC_LIMIT);
            end
            item.fin = (k == keep - 1);
            item.bad = 1'b0;
            pending_chars.push_back(item);
        end
    endfunction

    // Sends one value; the predicted string is queued once it is accepted.
    task automatic send_value(input logic [VALUE_W-1:0] v, input r2a_pkg::digit_t r);
        while ($urandom_range(99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        value     <= v;
        radix     <= r;
        @(posedge clk);
        while (!src_ready)
        begin
            @(posedge clk);
        end
        predict_digits(v, r);
        values_sent++;
        if (r < r2a_pkg::RADIX_MIN || r > r2a_pkg::RADIX_MAX)
        begin
            bad_radix_sent++;
        end
    endtask

    // Compares each accepted character with the oldest prediction.
    always @(posedge clk)
    begin
        digit_result_t want;
        if (rst_n && dst_valid && dst_ready)
        begin
            if (pending_chars.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                begin
                    $display("Unexpected character: char=%h last=%b bad_radix=%b",
                             digit_char, last, bad_radix);
                end
            end
            else
            begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (digit_char !== want.ch || last !== want.fin
                    || bad_radix !== want.bad)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                    begin
                        $display({"Mismatch: expected char=%h last=%b bad_radix=%b,",
                                  " got char=%h last=%b bad_radix=%b"},
                                 want.ch, want.fin, want.bad,
                                 digit_char, last, bad_radix);
                    end
                end
            end
        end
    end

    // Random value with a random bit length, so short strings are common.
    function automatic logic [VALUE_W-1:0] random_value();
        logic [31:0] word;
        word = $urandom();
        if ($urandom_range(7) != 0)
        begin
            word = word >> $urandom_range(31, 0);
        end
        return word[VALUE_W-1:0];
    endfunction

    // Zero and values that fit in one or two digits.
    task automatic test_short_strings();
        send_value('0, 6'd10);
        send_value('0, r2a_pkg::RADIX_MAX);
        send_value('0, r2a_pkg::RADIX_MIN);
        send_value(VALUE_W'(1), r2a_pkg::RADIX_MIN);
        send_value(VALUE_W'(9), 6'd10);
        send_value(VALUE_W'(10), 6'd11);
        send_value(VALUE_W'(35), r2a_pkg::RADIX_MAX);
        send_value(VALUE_W'(36), r2a_pkg::RADIX_MAX);
    endtask

    // Full-width values, including the longest string in radix 2.
    task automatic test_full_width();
        send_value('1, r2a_pkg::RADIX_MIN);
        send_value('1, 6'd3);
        send_value('1, 6'd10);
        send_value('1, 6'd16);
        send_value('1, r2a_pkg::RADIX_MAX);
        send_value(VALUE_W'(32'h5555_5555), r2a_pkg::RADIX_MIN);
        send_value(VALUE_W'(32'h2AAA_AAAA), r2a_pkg::RADIX_MIN);
        send_value(VALUE_W'(32'h4000_0000), 6'd35);
    endtask

    // Radixes outside 2 to 36 give a single flagged transaction.
    task automatic test_bad_radix();
        send_value(random_value(), 6'd0);
        send_value('1, 6'd1);
        send_value(random_value(), 6'd37);
        send_value('0, 6'd63);
        send_value(random_value(), 6'd48);
    endtask

    // Random values, mostly with legal radixes.
    task automatic test_random_traffic(input int count, input int src_pct,
                                       input int dst_pct);
        r2a_pkg::digit_t r;
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                r = r2a_pkg::digit_t'($urandom_range(63));
            end
            else
            begin
                r = r2a_pkg::digit_t'($urandom_range(36, 2));
            end
            send_value(random_value(), r);
        end
    endtask

    // The source holds off until every pending character has arrived.
    task automatic test_drained_restart();
        src_valid <= 1'b0;
        @(posedge clk);
        while (pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
        send_value(random_value(), r2a_pkg::digit_t'($urandom_range(36, 2)));
        send_value(random_value(), 6'd40);
        send_value('1, r2a_pkg::RADIX_MIN);
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (5)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_strings();
        test_full_width();
        test_bad_radix();
        test_random_traffic(95, 13, 55);
        test_drained_restart();
        test_random_traffic(95, 55, 13);
        test_random_traffic(95, 0, 0);

        // Let the last strings drain.
        src_valid <= 1'b0;
        while (pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES)
        begin
            @(posedge clk);
        end
        if (pending_chars.size() != 0)
        begin
            fail_count += pending_chars.size();
        end

        $display("Sent %0d values (%0d with an illegal radix), checked %0d characters.",
                 values_sent, bad_radix_sent, chars_checked);
        $display("Idling mixes: source 13/dest 55, source 55/dest 13, none; %0d failures.",
                 fail_count);
        if (fail_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
